// ===== src/bfac_pkg.sv =====
// Shared types and constants for the best-fit allocator.
package bfac_pkg;

    localparam int ADDR_BITS = 16;
    localparam int START_W  = 16;
    localparam int SIZE_W   = 17;
    localparam int STAMP_W  = 32;
    localparam int OUT_ID_W = 16;
    localparam int TOTAL_W  = 17;
    localparam int STATUS_W = 3;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 72;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_OK      = 3'd0;
    localparam status_t ST_NOFIT   = 3'd1;
    localparam status_t ST_ZERO    = 3'd2;
    localparam status_t ST_UNKNOWN = 3'd3;
    localparam status_t ST_FULL    = 3'd4;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_ASCAN  = 7'b0000010,
        S_AFIN   = 7'b0000100,
        S_RSCAN  = 7'b0001000,
        S_RMERGE = 7'b0010000,
        S_RFIN   = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic [SIZE_W-1:0]  size;
        logic [START_W-1:0] start;
    } free_ent_t;

    typedef struct packed {
        logic [TOTAL_W-1:0]  total;
        logic [START_W-1:0]  last;
        logic [START_W-1:0]  first;
        logic [OUT_ID_W-1:0] id;
        status_t             status;
    } result_t;

endpackage

// ===== src/bfac_ram.sv =====
// Generic simple dual-port RAM with registered read.
module bfac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== src/best_fit_allocator_coalescing_unit.sv =====
// Best-fit allocator with coalescing: top level, control and tables.
//
// Requests are handled one at a time. An allocate sweeps the free table once,
// one entry per cycle through its single read port. A release sweeps the
// allocation table once and, for a known id, the free table twice to merge
// neighbors. The result sits in an output register; the next request is
// taken once the block is back in idle. Writing the memory size register
// (address 0) reinitializes both tables at once; ids and stamps keep
// counting.
module best_fit_allocator_coalescing_unit #(
    parameter int MAX_ALLOCS = 64,
    parameter int ID_BITS    = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [bfac_pkg::S_DATA_W-1:0] s_tdata, // req_size, release_id, zero pad
    input  logic [0:0]  s_tuser,                   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [bfac_pkg::M_DATA_W-1:0] m_tdata  // status, block_id, block_start,
                                                   // block_end, allocated_total, zero pad
);
    import bfac_pkg::*;

    localparam int FREE_DEPTH = MAX_ALLOCS + 1;
    localparam int FIDX_W     = $clog2(FREE_DEPTH);
    localparam int AIDX_W     = $clog2(MAX_ALLOCS);
    localparam int CNT_W      = $clog2(FREE_DEPTH + 1);
    localparam int KEY_W      = ID_BITS + 1;
    localparam int AENT_W     = ID_BITS + 2 * START_W;
    localparam logic [17:0] MEM_LIM =
        (ADDR_BITS >= 17) ? 18'h20000 : 18'(64'd1 << ADDR_BITS);
    localparam logic [SIZE_W-1:0] RESET_SIZE =
        (ADDR_BITS >= 16) ? 17'h10000 : SIZE_W'(64'd1 << ADDR_BITS);

    state_t                state_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  pv_reg;
    logic [FIDX_W-1:0]     pidx_reg;
    logic                  pass_reg;
    logic [SIZE_W-1:0]     req_reg;
    logic [OUT_ID_W-1:0]   rid_reg;
    logic [SIZE_W-1:0]     mem_size_reg;
    logic                  e0_init_reg;
    logic [FREE_DEPTH-1:0] free_valid_reg;
    logic [MAX_ALLOCS-1:0] alloc_valid_reg;
    logic [KEY_W-1:0]      next_key_reg;
    logic [STAMP_W-1:0]    stamp_reg;
    logic [TOTAL_W-1:0]    live_reg;
    logic                  best_found_reg;
    logic [FIDX_W-1:0]     best_idx_reg;
    free_ent_t             best_ent_reg;
    logic                  slot_found_reg;
    logic [AIDX_W-1:0]     slot_reg;
    logic [START_W-1:0]    hit_first_reg;
    logic [START_W-1:0]    hit_last_reg;
    logic [START_W-1:0]    ns_reg;
    logic [SIZE_W-1:0]     nsize_reg;
    logic                  fslot_found_reg;
    logic [FIDX_W-1:0]     fslot_reg;
    result_t               res_reg;
    logic                  m_valid_reg;
    result_t               m_data_reg;

    // table ports
    logic               free_we;
    logic [FIDX_W-1:0]  free_waddr;
    free_ent_t          free_wdata;
    free_ent_t          free_rdata;
    logic               alloc_we;
    logic [AENT_W-1:0]  alloc_wdata;
    logic [AENT_W-1:0]  alloc_rdata;

    bfac_ram #(.WIDTH($bits(free_ent_t)), .DEPTH(FREE_DEPTH)) u_free_ram (
        .aclk  (aclk),
        .we    (free_we),
        .waddr (free_waddr),
        .wdata (free_wdata),
        .raddr (cnt_reg[FIDX_W-1:0]),
        .rdata (free_rdata)
    );

    bfac_ram #(.WIDTH(AENT_W), .DEPTH(MAX_ALLOCS)) u_alloc_ram (
        .aclk  (aclk),
        .we    (alloc_we),
        .waddr (slot_reg),
        .wdata (alloc_wdata),
        .raddr (cnt_reg[AIDX_W-1:0]),
        .rdata (alloc_rdata)
    );

    // read-side views
    free_ent_t            fe;
    logic                 fe_valid;
    logic [ID_BITS-1:0]   a_key;
    logic [START_W-1:0]   a_first;
    logic [START_W-1:0]   a_last;
    logic                 a_valid;
    logic                 cand;
    logic                 better;
    logic                 mrg_lo;
    logic                 mrg_hi;
    logic                 s_fire;
    logic                 cfg_wr;
    logic                 alloc_ok;
    logic                 split;
    logic [SIZE_W-1:0]    cfg_val;
    logic [SIZE_W-1:0]    rel_size;

    always_comb begin
        fe = free_rdata;
        if (pidx_reg == '0 && e0_init_reg) begin
            fe = '{stamp: '0, size: mem_size_reg, start: '0};
        end
        fe_valid = free_valid_reg[pidx_reg];
        a_key    = alloc_rdata[ID_BITS-1:0];
        a_first  = alloc_rdata[ID_BITS +: START_W];
        a_last   = alloc_rdata[ID_BITS+START_W +: START_W];
        a_valid  = alloc_valid_reg[AIDX_W'(pidx_reg)];
        cand     = fe_valid && fe.size >= req_reg;
        better   = !best_found_reg || fe.size < best_ent_reg.size ||
                   (fe.size == best_ent_reg.size && fe.stamp > best_ent_reg.stamp);
        mrg_lo   = (18'(fe.start) + 18'(fe.size)) == 18'(ns_reg);
        mrg_hi   = (18'(ns_reg) + 18'(nsize_reg)) == 18'(fe.start);
        rel_size = SIZE_W'(17'(hit_last_reg) - 17'(hit_first_reg) + 17'd1);
        alloc_ok = req_reg != '0 && slot_found_reg && !next_key_reg[KEY_W-1]
                   && best_found_reg;
        split    = best_ent_reg.size != req_reg;
        cfg_val  = pwdata[SIZE_W-1:0];
        if (cfg_val == '0) begin
            cfg_val = SIZE_W'(1);
        end
        if (18'(cfg_val) > MEM_LIM) begin
            cfg_val = MEM_LIM[SIZE_W-1:0];
        end
    end

    always_comb begin
        free_we    = 1'b0;
        free_waddr = best_idx_reg;
        free_wdata = '{stamp: stamp_reg, size: best_ent_reg.size - req_reg,
                       start: START_W'(17'(best_ent_reg.start) + req_reg)};
        if (state_reg == S_AFIN) begin
            free_we = alloc_ok && split;
        end else if (state_reg == S_RFIN) begin
            free_we    = fslot_found_reg;
            free_waddr = fslot_reg;
            free_wdata = '{stamp: stamp_reg, size: nsize_reg, start: ns_reg};
        end
        alloc_we    = state_reg == S_AFIN && alloc_ok;
        alloc_wdata = {START_W'(17'(best_ent_reg.start) + req_reg - 17'd1),
                       best_ent_reg.start, next_key_reg[ID_BITS-1:0]};
    end

    assign s_fire   = s_tvalid && s_tready;
    assign s_tready = state_reg == S_IDLE;
    assign cfg_wr   = psel && penable && pwrite && pready && paddr[2] == 1'b0;
    assign pready   = 1'b1;
    assign prdata   = 32'(mem_size_reg);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_W'(m_data_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            mem_size_reg    <= RESET_SIZE;
            e0_init_reg     <= 1'b1;
            free_valid_reg  <= FREE_DEPTH'(1);
            alloc_valid_reg <= '0;
            next_key_reg    <= '0;
            stamp_reg       <= STAMP_W'(1);
            live_reg        <= '0;
            m_valid_reg     <= 1'b0;
            cnt_reg         <= '0;
            pv_reg          <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end
            if (free_we) begin
                free_valid_reg[free_waddr] <= 1'b1;
                if (free_waddr == '0) begin
                    e0_init_reg <= 1'b0;
                end
                stamp_reg <= stamp_reg + STAMP_W'(1);
            end
            if (cfg_wr) begin
                mem_size_reg    <= cfg_val;
                e0_init_reg     <= 1'b1;
                free_valid_reg  <= FREE_DEPTH'(1);
                alloc_valid_reg <= '0;
                live_reg        <= '0;
            end
            pidx_reg <= cnt_reg[FIDX_W-1:0];
            case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        req_reg         <= s_tdata[SIZE_W-1:0];
                        rid_reg         <= s_tdata[SIZE_W +: OUT_ID_W];
                        cnt_reg         <= '0;
                        best_found_reg  <= 1'b0;
                        slot_found_reg  <= 1'b0;
                        fslot_found_reg <= 1'b0;
                        pass_reg        <= 1'b0;
                        state_reg       <= (s_tuser[0] == OP_RELEASE) ? S_RSCAN : S_ASCAN;
                    end
                end
                S_ASCAN: begin
                    pv_reg <= cnt_reg < CNT_W'(FREE_DEPTH);
                    if (cnt_reg < CNT_W'(FREE_DEPTH)) begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                    if (pv_reg) begin
                        if (cand && better) begin
                            best_found_reg <= 1'b1;
                            best_idx_reg   <= pidx_reg;
                            best_ent_reg   <= fe;
                        end
                        if (32'(pidx_reg) < MAX_ALLOCS && !a_valid && !slot_found_reg) begin
                            slot_found_reg <= 1'b1;
                            slot_reg       <= AIDX_W'(pidx_reg);
                        end
                    end else if (cnt_reg == CNT_W'(FREE_DEPTH)) begin
                        state_reg <= S_AFIN;
                    end
                end
                S_AFIN: begin
                    if (req_reg == '0) begin
                        res_reg <= '{status: ST_ZERO, id: '0, first: '0, last: '0,
                                     total: live_reg};
                    end else if (!slot_found_reg || next_key_reg[KEY_W-1]) begin
                        res_reg <= '{status: ST_FULL, id: '0, first: '0, last: '0,
                                     total: live_reg};
                    end else if (!best_found_reg) begin
                        res_reg <= '{status: ST_NOFIT, id: '0, first: '0, last: '0,
                                     total: live_reg};
                    end else begin
                        if (!split) begin
                            free_valid_reg[best_idx_reg] <= 1'b0;
                        end
                        alloc_valid_reg[slot_reg] <= 1'b1;
                        next_key_reg   <= next_key_reg + KEY_W'(1);
                        live_reg       <= TOTAL_W'(live_reg + req_reg);
                        res_reg <= '{status: ST_OK,
                                     id: OUT_ID_W'(next_key_reg[ID_BITS-1:0]),
                                     first: best_ent_reg.start,
                                     last: START_W'(17'(best_ent_reg.start) + req_reg
                                                    - 17'd1),
                                     total: TOTAL_W'(live_reg + req_reg)};
                    end
                    state_reg <= S_DONE;
                end
                S_RSCAN: begin
                    pv_reg <= cnt_reg < CNT_W'(MAX_ALLOCS);
                    if (cnt_reg < CNT_W'(MAX_ALLOCS)) begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                    if (pv_reg) begin
                        if (a_valid && OUT_ID_W'(a_key) == rid_reg && !slot_found_reg) begin
                            slot_found_reg <= 1'b1;
                            slot_reg       <= AIDX_W'(pidx_reg);
                            hit_first_reg  <= a_first;
                            hit_last_reg   <= a_last;
                        end
                    end else if (cnt_reg == CNT_W'(MAX_ALLOCS)) begin
                        if (!slot_found_reg) begin
                            res_reg <= '{status: ST_UNKNOWN, id: rid_reg, first: '0,
                                         last: '0, total: live_reg};
                            state_reg <= S_DONE;
                        end else begin
                            alloc_valid_reg[slot_reg] <= 1'b0;
                            live_reg  <= (live_reg >= rel_size) ? live_reg - rel_size : '0;
                            ns_reg    <= hit_first_reg;
                            nsize_reg <= rel_size;
                            cnt_reg   <= '0;
                            state_reg <= S_RMERGE;
                        end
                    end
                end
                S_RMERGE: begin
                    pv_reg <= cnt_reg < CNT_W'(FREE_DEPTH);
                    if (cnt_reg < CNT_W'(FREE_DEPTH)) begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                    if (pv_reg) begin
                        if (fe_valid && mrg_lo) begin
                            ns_reg    <= fe.start;
                            nsize_reg <= nsize_reg + fe.size;
                            free_valid_reg[pidx_reg] <= 1'b0;
                        end else if (fe_valid && mrg_hi) begin
                            nsize_reg <= nsize_reg + fe.size;
                            free_valid_reg[pidx_reg] <= 1'b0;
                        end
                        if (pass_reg && !fslot_found_reg &&
                            (!fe_valid || mrg_lo || mrg_hi)) begin
                            fslot_found_reg <= 1'b1;
                            fslot_reg       <= pidx_reg;
                        end
                    end else if (cnt_reg == CNT_W'(FREE_DEPTH)) begin
                        if (!pass_reg) begin
                            pass_reg <= 1'b1;
                            cnt_reg  <= '0;
                        end else begin
                            state_reg <= S_RFIN;
                        end
                    end
                end
                S_RFIN: begin
                    res_reg <= '{status: ST_OK, id: rid_reg, first: hit_first_reg,
                                 last: hit_last_reg, total: live_reg};
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= res_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_live_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        18'(live_reg) <= 18'(mem_size_reg))
        else $error("allocated total exceeds memory size");
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_tready)
        else $error("request taken while another is in progress");
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(FREE_DEPTH))
        else $error("scan counter out of range");
    a_key_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        next_key_reg[KEY_W-1] |-> next_key_reg[KEY_W-2:0] == '0)
        else $error("id counter past exhaustion");
`endif

endmodule

// ===== sim/best_fit_allocator_coalescing_unit_tb.sv =====
// Self-checking testbench for the best-fit allocator with coalescing.
module best_fit_allocator_coalescing_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bfac_pkg::*;

    localparam int NFREE  = 65;
    localparam int NALLOC = 64;
    localparam int LAT    = 3 * NALLOC + 20;

    typedef struct packed {
        logic              op;
        logic [SIZE_W-1:0] req_size;
        logic [15:0]       rel_id;
    } request_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    best_fit_allocator_coalescing_unit dut (.*);

    // allocator mirror
    logic [16:0]  mem_units;
    logic [15:0]  fr_start [NFREE];
    logic [16:0]  fr_size  [NFREE];
    logic [31:0]  fr_stamp [NFREE];
    logic         fr_live  [NFREE];
    logic         al_live  [NALLOC];
    logic [15:0]  al_key   [NALLOC];
    logic [15:0]  al_first [NALLOC];
    logic [15:0]  al_last  [NALLOC];
    logic [16:0]  id_count;
    logic [31:0]  stamp_ctr;
    logic [16:0]  units_out;

    request_t pending_reqs[$];
    result_t  expected_results[$];
    int       errors = 0;
    int       rx_hold = 0;
    int       hold_asks = 0;
    int       hold_seen = 0;
    int       live_ids[$];
    logic     s_took = 1'b0;

    initial forever #1 aclk = ~aclk;

    initial begin
        #20_000_000;
        $display("** best_fit_allocator_coalescing_unit: FAILED **");
        $finish;
    end

    function automatic void clear_tables();
        for (int i = 0; i < NFREE; i++) fr_live[i] = 1'b0;
        for (int i = 0; i < NALLOC; i++) al_live[i] = 1'b0;
        fr_start[0] = '0;
        fr_size[0] = mem_units;
        fr_stamp[0] = '0;
        fr_live[0] = 1'b1;
        units_out = '0;
        live_ids.delete();
    endfunction

    function automatic logic [31:0] next_stamp();
        logic [31:0] s;
        s = stamp_ctr;
        stamp_ctr = stamp_ctr + 1;
        return s;
    endfunction

    function automatic void merge_pass(ref logic [16:0] ns, ref logic [16:0] nsz);
        for (int i = 0; i < NFREE; i++) begin
            if (!fr_live[i]) continue;
            if (17'(fr_start[i]) + fr_size[i] == ns) begin
                ns = 17'(fr_start[i]);
                nsz += fr_size[i];
                fr_live[i] = 1'b0;
            end else if (ns + nsz == 17'(fr_start[i])) begin
                nsz += fr_size[i];
                fr_live[i] = 1'b0;
            end
        end
    endfunction

    function automatic result_t allocate_or_release(request_t rq);
        result_t r;
        int aslot, best, hit, fslot;
        logic [16:0] ns, nsz, s;
        r = '0;
        aslot = -1; best = -1; hit = -1; fslot = -1;
        if (rq.op == OP_ALLOC) begin
            for (int i = 0; i < NALLOC; i++)
                if (!al_live[i]) begin aslot = i; break; end
            if (rq.req_size == 0) r.status = ST_ZERO;
            else if (aslot < 0 || id_count[16]) r.status = ST_FULL;
            else begin
                for (int i = 0; i < NFREE; i++) begin
                    if (!fr_live[i] || fr_size[i] < rq.req_size) continue;
                    if (best < 0 || fr_size[i] < fr_size[best] ||
                        (fr_size[i] == fr_size[best] && fr_stamp[i] > fr_stamp[best]))
                        best = i;
                end
                if (best < 0) r.status = ST_NOFIT;
                else begin
                    s = 17'(fr_start[best]);
                    if (fr_size[best] == rq.req_size) fr_live[best] = 1'b0;
                    else begin
                        fr_start[best] = 16'(s + rq.req_size);
                        fr_size[best] = fr_size[best] - rq.req_size;
                        fr_stamp[best] = next_stamp();
                    end
                    al_live[aslot] = 1'b1;
                    al_key[aslot] = id_count[15:0];
                    al_first[aslot] = s[15:0];
                    al_last[aslot] = 16'(s + rq.req_size - 1);
                    r.status = ST_OK;
                    r.id = id_count[15:0];
                    r.first = al_first[aslot];
                    r.last = al_last[aslot];
                    live_ids.push_back(id_count[15:0]);
                    id_count++;
                    units_out += rq.req_size;
                end
            end
        end else begin
            for (int i = 0; i < NALLOC; i++)
                if (al_live[i] && al_key[i] == rq.rel_id) begin hit = i; break; end
            r.id = rq.rel_id;
            if (hit < 0) r.status = ST_UNKNOWN;
            else begin
                ns = 17'(al_first[hit]);
                nsz = 17'(al_last[hit]) - 17'(al_first[hit]) + 1;
                r.status = ST_OK;
                r.first = al_first[hit];
                r.last = al_last[hit];
                al_live[hit] = 1'b0;
                units_out = (units_out >= nsz) ? units_out - nsz : '0;
                merge_pass(ns, nsz);
                merge_pass(ns, nsz);
                for (int i = 0; i < NFREE; i++)
                    if (!fr_live[i]) begin fslot = i; break; end
                if (fslot >= 0) begin
                    fr_live[fslot] = 1'b1;
                    fr_start[fslot] = ns[15:0];
                    fr_size[fslot] = nsz;
                    fr_stamp[fslot] = next_stamp();
                end
                foreach (live_ids[k]) if (live_ids[k] == rq.rel_id) begin
                    live_ids.delete(k);
                    break;
                end
            end
        end
        r.total = units_out;
        return r;
    endfunction

    function automatic int gap_cycles();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 90) return $urandom_range(1, 3);
        if (p < 98) return $urandom_range(4, 20);
        return $urandom_range(40, 150);
    endfunction

    always @(posedge aclk) begin
        s_took <= s_tvalid && s_tready;
    end

    // driver
    int tx_gap = 0;
    always @(negedge aclk) begin
        request_t rq;
        if (aresetn) begin
            if (s_tvalid && !s_took) begin
            end else if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                rq = pending_reqs.pop_front();
                s_tdata <= {7'b0, rq.rel_id, rq.req_size};
                s_tuser <= rq.op;
                s_tvalid <= 1'b1;
                tx_gap <= gap_cycles();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (hold_asks != hold_seen) begin
                hold_seen <= hold_asks;
                rx_hold <= 300;
                m_tready <= 1'b0;
            end else if (rx_hold > 0) begin
                rx_hold <= rx_hold - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= (gap_cycles() == 0);
            end
        end
    end

    // monitor: predict on accept, check on result
    always @(posedge aclk) begin
        request_t rq;
        result_t got, want;
        if (aresetn && s_tvalid && s_tready) begin
            rq.op = s_tuser[0];
            rq.req_size = s_tdata[16:0];
            rq.rel_id = s_tdata[32:17];
            expected_results.push_back(allocate_or_release(rq));
        end
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[$bits(result_t)-1:0]);
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status || got.id !== want.id ||
                    got.first !== want.first || got.last !== want.last ||
                    got.total !== want.total) begin
                    $display("%0t: mismatch expected st=%0d id=%0d [%0d..%0d] tot=%0d",
                             $time, want.status, want.id, want.first, want.last,
                             want.total);
                    $display("%0t:          actual   st=%0d id=%0d [%0d..%0d] tot=%0d",
                             $time, got.status, got.id, got.first, got.last, got.total);
                    errors++;
                end
            end
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (LAT) @(posedge aclk);
    endtask

    task automatic write_size(logic [31:0] v);
        @(negedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= v;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        v = v & 32'h1FFFF;
        if (v == 0) v = 1;
        if (v > 65536) v = 65536;
        mem_units = v[16:0];
        clear_tables();
    endtask

    function automatic void push_alloc(int sz);
        request_t rq;
        rq.op = OP_ALLOC; rq.req_size = 17'(sz); rq.rel_id = 16'($urandom);
        pending_reqs.push_back(rq);
    endfunction

    function automatic void push_release(int id);
        request_t rq;
        rq.op = OP_RELEASE; rq.req_size = 17'($urandom); rq.rel_id = 16'(id);
        pending_reqs.push_back(rq);
    endfunction

    task automatic random_phase(int count, int maxsz);
        int pick;
        for (int n = 0; n < count; n++) begin
            // keep the mirror in step so releases target live ids
            while (pending_reqs.size() > 4) @(posedge aclk);
            pick = $urandom_range(0, 99);
            if (pick < 50) push_alloc($urandom_range(1, maxsz));
            else if (pick < 85 && live_ids.size() > 0)
                push_release(live_ids[$urandom_range(0, live_ids.size() - 1)]);
            else if (pick < 90) push_alloc(0);
            else if (pick < 95) push_release($urandom_range(0, 65535));
            else push_alloc($urandom_range(1, 131071));
        end
    endtask

    initial begin
        mem_units = 17'd65536;
        id_count = '0;
        stamp_ctr = 32'd1;
        clear_tables();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed
        push_alloc(0);
        push_alloc(65536);
        push_release(0);
        push_release(0);
        push_release(65535);
        push_alloc(65537);
        push_alloc(131071);
        push_alloc(1);
        push_alloc(100);
        push_alloc(1);
        push_release(2);
        push_alloc(1);
        push_release(1);
        push_release(3);
        push_release(4);
        push_alloc(65536);
        wait_drained();

        write_size(32'd0);
        push_alloc(1); push_alloc(1); push_release(6);
        wait_drained();

        write_size(32'd96);
        for (int i = 0; i < 70; i++) pending_reqs.push_back('{OP_ALLOC, 17'd1, 16'd0});
        hold_asks++;
        wait_drained();
        random_phase(500, 6);
        wait_drained();

        write_size(32'h1FFFF);
        random_phase(500, 4000);
        wait_drained();

        write_size(32'd1000);
        random_phase(600, 60);
        wait_drained();

        if (errors == 0)
            $display("** best_fit_allocator_coalescing_unit: PASSED **");
        else
            $display("** best_fit_allocator_coalescing_unit: FAILED **");
        $finish;
    end
endmodule

// ===== files.f =====
src/bfac_pkg.sv
src/bfac_ram.sv
src/best_fit_allocator_coalescing_unit.sv
sim/best_fit_allocator_coalescing_unit_tb.sv
